>>> hdl/dpsc_pkg.sv
// Package: widths, codes and word types of the DXT1 payload shape check.
`default_nettype none
package dpsc_pkg;

   localparam int EDGE_WIDTH        = 16;
   localparam int LEN_W             = 32;
   localparam int LEVELS_W          = 5;
   localparam int MAX_EDGE_W        = 16;
   localparam int CSR_DATA_W        = 32;
   localparam int CSR_INDEX_W       = 1;

   localparam int BLOCK_SHIFT       = 2;
   localparam int BLOCK_ROUND       = 3;
   localparam int BLOCK_BYTES_SHIFT = 3;

   localparam int NUM_LANES  = EDGE_WIDTH;
   localparam int BLK_W      = EDGE_WIDTH + 1 - BLOCK_SHIFT;
   localparam int LVL_W      = 2 * BLK_W + BLOCK_BYTES_SHIFT;
   localparam int SUM_W      = (LVL_W + 1 > LEN_W + 1) ? LVL_W + 1 : LEN_W + 1;
   localparam int GROUP_SIZE = 4;
   localparam int NUM_GROUPS = (NUM_LANES + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam int CMP_W      = (EDGE_WIDTH > MAX_EDGE_W) ? EDGE_WIDTH : MAX_EDGE_W;

   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_EDGE_TEXELS   = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_PAYLOAD_BYTES = 1'b1;

   localparam logic [MAX_EDGE_W-1:0] MAX_EDGE_RESET    = 16'd4096;
   localparam logic [LEN_W-1:0]      MAX_PAYLOAD_RESET = 32'd16777216;

   typedef struct packed {
      logic                  status_found;
      logic [EDGE_WIDTH-1:0] edge_texels;
      logic [LEN_W-1:0]      byte_length;
   } req_word_type;

   typedef struct packed {
      logic                payload_valid;
      logic [LEVELS_W-1:0] mip_levels;
      logic [LEN_W-1:0]    full_chain_bytes;
   } rsp_word_type;

   typedef struct packed {
      logic                ok;
      logic [LEN_W-1:0]    len;
      logic [LEVELS_W-1:0] levels;
   } item_tag_type;

   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
   } stage_adv_type;

endpackage
`default_nettype wire

>>> hdl/dpsc_level_lanes.sv
// Per-level lanes: block counts of each mip level, then level byte sizes.
`default_nettype none
module dpsc_level_lanes (
   input  wire logic                                        clock,
   input  wire dpsc_pkg::stage_adv_type                     adv,
   input  wire dpsc_pkg::req_word_type                      req_word,
   input  wire logic [dpsc_pkg::MAX_EDGE_W-1:0]             max_edge,
   input  wire logic [dpsc_pkg::LEN_W-1:0]                  max_payload,
   output logic [dpsc_pkg::NUM_LANES-1:0][dpsc_pkg::LVL_W-1:0] lane_bytes,
   output dpsc_pkg::item_tag_type                           tag
);
   import dpsc_pkg::*;

   logic [NUM_LANES-1:0][BLK_W-1:0] blk_in, blk_ff;
   logic [NUM_LANES-1:0]            lane_on_in, lane_on_ff;
   logic [NUM_LANES-1:0][LVL_W-1:0] bytes_in, bytes_ff;
   logic [EDGE_WIDTH-1:0]           side [NUM_LANES];
   logic [EDGE_WIDTH:0]             rounded [NUM_LANES];
   logic [2*BLK_W-1:0]              sq [NUM_LANES];
   item_tag_type                    tag1_in, tag1_ff, tag2_ff;
   logic [LEVELS_W-1:0]             levels;
   logic                            edge_ok, len_ok;

   always_comb begin
      for (int i = 0; i < NUM_LANES; i++) begin
         side[i]       = req_word.edge_texels >> i;
         rounded[i]    = {1'b0, side[i]} + (EDGE_WIDTH+1)'(BLOCK_ROUND);
         blk_in[i]     = rounded[i][EDGE_WIDTH:BLOCK_SHIFT];
         lane_on_in[i] = (side[i] != '0);
      end
   end

   always_comb begin
      levels = '0;
      for (int i = 0; i < EDGE_WIDTH; i++) begin
         if (req_word.edge_texels[i]) begin
            levels = LEVELS_W'(i + 1);
         end
      end
   end

   assign edge_ok = (req_word.edge_texels != '0) &&
                    (CMP_W'(req_word.edge_texels) <= CMP_W'(max_edge));
   assign len_ok  = (req_word.byte_length != '0) &&
                    (req_word.byte_length <= max_payload);

   always_comb begin
      tag1_in.ok     = req_word.status_found && edge_ok && len_ok;
      tag1_in.len    = req_word.byte_length;
      tag1_in.levels = levels;
   end

   always_comb begin
      for (int i = 0; i < NUM_LANES; i++) begin
         sq[i]       = blk_ff[i] * blk_ff[i];
         bytes_in[i] = lane_on_ff[i] ? {sq[i], {BLOCK_BYTES_SHIFT{1'b0}}} : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv.s1) begin
         blk_ff     <= blk_in;
         lane_on_ff <= lane_on_in;
         tag1_ff    <= tag1_in;
      end
      if (adv.s2) begin
         bytes_ff <= bytes_in;
         tag2_ff  <= tag1_ff;
      end
   end

   assign lane_bytes = bytes_ff;
   assign tag        = tag2_ff;

endmodule
`default_nettype wire

>>> hdl/dpsc_chain_sum.sv
// Chain adder tree: group sums of level sizes, then the full-chain total.
`default_nettype none
module dpsc_chain_sum (
   input  wire logic                                           clock,
   input  wire dpsc_pkg::stage_adv_type                        adv,
   input  wire logic [dpsc_pkg::NUM_LANES-1:0][dpsc_pkg::LVL_W-1:0] lane_bytes,
   input  wire dpsc_pkg::item_tag_type                         tag_in,
   output logic [dpsc_pkg::SUM_W-1:0]                          total,
   output logic [dpsc_pkg::SUM_W-1:0]                          base,
   output dpsc_pkg::item_tag_type                              tag_out
);
   import dpsc_pkg::*;

   logic [NUM_GROUPS-1:0][SUM_W-1:0] grp_in, grp_ff;
   logic [SUM_W-1:0]                 base3_ff, base4_ff, total_in, total_ff;
   item_tag_type                     tag3_ff, tag4_ff;

   always_comb begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
         grp_in[g] = '0;
         for (int j = 0; j < GROUP_SIZE; j++) begin
            if (g * GROUP_SIZE + j < NUM_LANES) begin
               grp_in[g] = grp_in[g] + SUM_W'(lane_bytes[g * GROUP_SIZE + j]);
            end
         end
      end
   end

   always_comb begin
      total_in = '0;
      for (int g = 0; g < NUM_GROUPS; g++) begin
         total_in = total_in + grp_ff[g];
      end
   end

   always_ff @(posedge clock) begin
      if (adv.s3) begin
         grp_ff   <= grp_in;
         base3_ff <= SUM_W'(lane_bytes[0]);
         tag3_ff  <= tag_in;
      end
      if (adv.s4) begin
         total_ff <= total_in;
         base4_ff <= base3_ff;
         tag4_ff  <= tag3_ff;
      end
   end

   assign total   = total_ff;
   assign base    = base4_ff;
   assign tag_out = tag4_ff;

endmodule
`default_nettype wire

>>> hdl/dxt1_payload_shape_check_top.sv
// Top level: limit registers, pipeline control and the result stage.
//
//   channel  direction  ports                                   word
//   req      in         req_valid, req_ready, req_word          req_word_type
//   rsp      out        rsp_valid, rsp_ready, rsp_word          rsp_word_type
//   csr      in         csr_write_enable, csr_index, csr_write_data
//
// Five register stages: block counts, level squares, group sums, chain total,
// result compare. One word enters per cycle while req_ready is high.
// Reset clears the stage valid bits and loads the default limits.
// A stalled rsp fills the empty stages first, then holds req_ready low.
`default_nettype none
module dxt1_payload_shape_check_top (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire dpsc_pkg::req_word_type              req_word,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output dpsc_pkg::rsp_word_type                   rsp_word,
   input  wire logic                                csr_write_enable,
   input  wire logic [dpsc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [dpsc_pkg::CSR_DATA_W-1:0]     csr_write_data
);
   import dpsc_pkg::*;

   logic [MAX_EDGE_W-1:0] max_edge_ff;
   logic [LEN_W-1:0]      max_payload_ff;
   logic [4:0]            stage_v_in, stage_v_ff;
   logic [4:0]            en;
   stage_adv_type         adv;

   logic [NUM_LANES-1:0][LVL_W-1:0] lane_bytes;
   item_tag_type                    tag2, tag4;
   logic [SUM_W-1:0]                total, base;
   logic                            match_full, match_base;
   rsp_word_type                    rsp_in, rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_edge_ff    <= MAX_EDGE_RESET;
         max_payload_ff <= MAX_PAYLOAD_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_MAX_EDGE_TEXELS:   max_edge_ff    <= csr_write_data[MAX_EDGE_W-1:0];
            CSR_MAX_PAYLOAD_BYTES: max_payload_ff <= csr_write_data[LEN_W-1:0];
         endcase
      end
   end

   assign en[4] = !stage_v_ff[4] || rsp_ready;
   assign en[3] = !stage_v_ff[3] || en[4];
   assign en[2] = !stage_v_ff[2] || en[3];
   assign en[1] = !stage_v_ff[1] || en[2];
   assign en[0] = !stage_v_ff[0] || en[1];

   always_comb begin
      adv.s1 = en[0];
      adv.s2 = en[1];
      adv.s3 = en[2];
      adv.s4 = en[3];
   end

   always_comb begin
      stage_v_in = stage_v_ff;
      if (en[0]) begin
         stage_v_in[0] = req_valid;
      end
      for (int k = 1; k < 5; k++) begin
         if (en[k]) begin
            stage_v_in[k] = stage_v_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_v_ff <= '0;
      end else begin
         stage_v_ff <= stage_v_in;
      end
   end

   dpsc_level_lanes u_lanes (
      .clock       (clock),
      .adv         (adv),
      .req_word    (req_word),
      .max_edge    (max_edge_ff),
      .max_payload (max_payload_ff),
      .lane_bytes  (lane_bytes),
      .tag         (tag2)
   );

   dpsc_chain_sum u_sum (
      .clock      (clock),
      .adv        (adv),
      .lane_bytes (lane_bytes),
      .tag_in     (tag2),
      .total      (total),
      .base       (base),
      .tag_out    (tag4)
   );

   assign match_full = (SUM_W'(tag4.len) == total);
   assign match_base = (SUM_W'(tag4.len) == base);

   always_comb begin
      rsp_in.payload_valid = tag4.ok && (match_full || match_base);
      if (!tag4.ok) begin
         rsp_in.mip_levels = '0;
      end else if (match_full) begin
         rsp_in.mip_levels = tag4.levels;
      end else if (match_base) begin
         rsp_in.mip_levels = LEVELS_W'(1);
      end else begin
         rsp_in.mip_levels = '0;
      end
      rsp_in.full_chain_bytes = (total[SUM_W-1:LEN_W] != '0) ? '1 : total[LEN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign req_ready = en[0];
   assign rsp_valid = stage_v_ff[4];
   assign rsp_word  = rsp_ff;

endmodule
`default_nettype wire

>>> tb/tb.sv
// Testbench for the DXT1 payload shape check: directed table, random words, scoreboard.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import dpsc_pkg::*;

   localparam int STALL_LIMIT    = 4000;
   localparam int DRAIN_CYCLES   = 10;
   localparam int PHASE_WORDS    = 175;
   localparam int NUM_PHASES     = 6;

   typedef struct packed {
      logic                  fnd;
      logic [EDGE_WIDTH-1:0] edge_tx;
      logic [LEN_W-1:0]      len;
      logic                  typed;
      logic                  ok;
      logic [LEVELS_W-1:0]   lv;
      logic [LEN_W-1:0]      nbytes;
   } shape_row_type;

   localparam int NUM_ROWS = 20;
   localparam shape_row_type SHAPE_ROWS [NUM_ROWS] = '{
      '{1'b1, 16'd0,      32'd0,          1'b1, 1'b0, 5'd0,  32'd0},
      '{1'b1, 16'd0,      32'hFFFFFFFF,   1'b1, 1'b0, 5'd0,  32'd0},
      '{1'b1, 16'd1,      32'd8,          1'b1, 1'b1, 5'd1,  32'd8},
      '{1'b1, 16'd1,      32'd16,         1'b1, 1'b0, 5'd0,  32'd8},
      '{1'b0, 16'd1,      32'd8,          1'b1, 1'b0, 5'd0,  32'd8},
      '{1'b1, 16'd4,      32'd24,         1'b1, 1'b1, 5'd3,  32'd24},
      '{1'b1, 16'd4,      32'd8,          1'b1, 1'b1, 5'd1,  32'd24},
      '{1'b1, 16'd4,      32'd0,          1'b1, 1'b0, 5'd0,  32'd24},
      '{1'b1, 16'hFFFF,   32'hFFFFFFFF,   1'b0, 1'b0, 5'd0,  32'd0},
      '{1'b1, 16'd4096,   32'd8388608,    1'b0, 1'b0, 5'd0,  32'd0},
      '{1'b1, 16'd4096,   32'd11184824,   1'b0, 1'b0, 5'd0,  32'd0},
      '{1'b1, 16'd4097,   32'h00AAAAAA,   1'b0, 1'b0, 5'd0,  32'd0},
      '{1'b1, 16'd3,      32'd16,         1'b1, 1'b1, 5'd2,  32'd16},
      '{1'b1, 16'd5,      32'd48,         1'b0, 1'b0, 5'd0,  32'd0},
      '{1'b1, 16'h5555,   32'h55555555,   1'b0, 1'b0, 5'd0,  32'd0},
      '{1'b1, 16'hAAAA,   32'hAAAAAAAA,   1'b0, 1'b0, 5'd0,  32'd0},
      '{1'b1, 16'd2,      32'd8,          1'b1, 1'b1, 5'd1,  32'd16},
      '{1'b1, 16'd7,      32'd1,          1'b0, 1'b0, 5'd0,  32'd0},
      '{1'b0, 16'hFFFF,   32'd0,          1'b0, 1'b0, 5'd0,  32'd0},
      '{1'b1, 16'd8,      32'd32,         1'b1, 1'b1, 5'd1,  32'd56}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_word_type req_word = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_word_type rsp_word;
   logic csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;

   logic [MAX_EDGE_W-1:0] cfg_max_edge = MAX_EDGE_RESET;
   logic [LEN_W-1:0] cfg_max_payload = MAX_PAYLOAD_RESET;

   rsp_word_type shape_expect_q[$];
   int mismatches = 0;
   int idle_cycles = 0;
   int burst_left = 0;

   dxt1_payload_shape_check_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_word         (req_word),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_word         (rsp_word),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic logic [63:0] level_block_bytes(logic [63:0] side);
      logic [63:0] blocks;
      blocks = (side + BLOCK_ROUND) >> BLOCK_SHIFT;
      if (blocks == 0) begin
         blocks = 64'd1;
      end
      return (blocks * blocks) << BLOCK_BYTES_SHIFT;
   endfunction

   function automatic logic [63:0] mip_chain_bytes(logic [EDGE_WIDTH-1:0] edge_tx);
      logic [63:0] total;
      logic [63:0] side;
      total = '0;
      side = 64'(edge_tx);
      if (edge_tx != 0) begin
         for (int i = 0; i <= EDGE_WIDTH; i++) begin
            total += level_block_bytes(side);
            if (side <= 1) begin
               break;
            end
            side >>= 1;
         end
      end
      return total;
   endfunction

   function automatic logic [LEN_W-1:0] clip32(logic [63:0] v);
      return (v > 64'hFFFFFFFF) ? '1 : v[LEN_W-1:0];
   endfunction

   function automatic rsp_word_type predict_shape(req_word_type w);
      rsp_word_type r;
      logic [63:0] full;
      logic [63:0] base;
      full = mip_chain_bytes(w.edge_texels);
      base = level_block_bytes(64'(w.edge_texels));
      r = '0;
      r.full_chain_bytes = clip32(full);
      if (w.status_found && w.edge_texels != 0 && w.edge_texels <= cfg_max_edge &&
          w.byte_length != 0 && w.byte_length <= cfg_max_payload) begin
         if (64'(w.byte_length) == full) begin
            r.payload_valid = 1'b1;
            r.mip_levels = LEVELS_W'($clog2(32'(w.edge_texels) + 1));
         end else if (64'(w.byte_length) == base) begin
            r.payload_valid = 1'b1;
            r.mip_levels = LEVELS_W'(1);
         end
      end
      return r;
   endfunction

   function automatic req_word_type random_shape_word();
      req_word_type w;
      int unsigned hi;
      int unsigned e;
      logic [63:0] full;
      logic [63:0] base;
      hi = (cfg_max_edge < 512) ? cfg_max_edge : 512;
      w.status_found = ($urandom_range(0, 15) != 0);
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: e = $urandom_range(1, hi);
         6, 7: e = $urandom_range(0, 65535);
         8: begin
            e = cfg_max_edge + $urandom_range(0, 2);
            if (e > 65535) begin
               e = 65535;
            end
         end
         default: e = $urandom_range(0, 3);
      endcase
      w.edge_texels = e[EDGE_WIDTH-1:0];
      full = mip_chain_bytes(w.edge_texels);
      base = level_block_bytes(64'(w.edge_texels));
      case ($urandom_range(0, 11))
         0, 1, 2, 3, 4: w.byte_length = clip32(full);
         5, 6: w.byte_length = clip32(base);
         7: w.byte_length = ($urandom_range(0, 1) != 0) ? clip32(full + 1) : clip32(full - 1);
         8: w.byte_length = '0;
         9: w.byte_length = cfg_max_payload + $urandom_range(0, 1);
         default: w.byte_length = $urandom();
      endcase
      return w;
   endfunction

   task automatic send_word(req_word_type w, logic typed, rsp_word_type typed_rsp);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            @(negedge clock) req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      shape_expect_q.push_back(typed ? typed_rsp : predict_shape(w));
   endtask

   task automatic drain_words();
      @(negedge clock) req_valid <= 1'b0;
      while (shape_expect_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= val;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_MAX_EDGE_TEXELS) begin
         cfg_max_edge = val[MAX_EDGE_W-1:0];
      end else begin
         cfg_max_payload = val[LEN_W-1:0];
      end
   endtask

   initial begin : rsp_stall_pattern
      int cyc;
      int mode;
      cyc = 0;
      mode = 0;
      forever begin
         @(negedge clock);
         if (cyc % 48 == 0) begin
            mode = $urandom_range(0, 3);
         end
         case (mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 9) < 7);
            2: rsp_ready <= (cyc % 5 != 0);
            default: rsp_ready <= ($urandom_range(0, 9) < 3);
         endcase
         cyc++;
      end
   end

   always @(posedge clock) begin : rsp_check
      rsp_word_type exp_w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (shape_expect_q.size() == 0) begin
            $error("unexpected rsp word %h", rsp_word);
            mismatches++;
         end else begin
            exp_w = shape_expect_q.pop_front();
            if (rsp_word.payload_valid !== exp_w.payload_valid) begin
               $error("payload_valid expected %0d actual %0d",
                      exp_w.payload_valid, rsp_word.payload_valid);
               mismatches++;
            end
            if (rsp_word.mip_levels !== exp_w.mip_levels) begin
               $error("mip_levels expected %0d actual %0d",
                      exp_w.mip_levels, rsp_word.mip_levels);
               mismatches++;
            end
            if (rsp_word.full_chain_bytes !== exp_w.full_chain_bytes) begin
               $error("full_chain_bytes expected %0d actual %0d",
                      exp_w.full_chain_bytes, rsp_word.full_chain_bytes);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin : stimulus
      req_word_type w;
      rsp_word_type r;
      logic [CSR_DATA_W-1:0] rnd_payload;
      repeat (5) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      foreach (SHAPE_ROWS[i]) begin
         w.status_found = SHAPE_ROWS[i].fnd;
         w.edge_texels = SHAPE_ROWS[i].edge_tx;
         w.byte_length = SHAPE_ROWS[i].len;
         r.payload_valid = SHAPE_ROWS[i].ok;
         r.mip_levels = SHAPE_ROWS[i].lv;
         r.full_chain_bytes = SHAPE_ROWS[i].nbytes;
         send_word(w, SHAPE_ROWS[i].typed, r);
      end

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         if (ph > 0) begin
            drain_words();
            case (ph)
               1: begin
                  write_limit(CSR_MAX_EDGE_TEXELS, 32'd65535);
                  write_limit(CSR_MAX_PAYLOAD_BYTES, 32'hFFFFFFFF);
               end
               2: begin
                  write_limit(CSR_MAX_EDGE_TEXELS, 32'd1);
                  write_limit(CSR_MAX_PAYLOAD_BYTES, 32'd1);
               end
               3: begin
                  write_limit(CSR_MAX_EDGE_TEXELS, 32'd300);
                  write_limit(CSR_MAX_PAYLOAD_BYTES, 32'd6000);
               end
               4: begin
                  rnd_payload = $urandom();
                  if (rnd_payload == 0) begin
                     rnd_payload = 1;
                  end
                  write_limit(CSR_MAX_EDGE_TEXELS, 32'($urandom_range(1, 65535)));
                  write_limit(CSR_MAX_PAYLOAD_BYTES, rnd_payload);
               end
               default: begin
                  write_limit(CSR_MAX_EDGE_TEXELS, 32'(MAX_EDGE_RESET));
                  write_limit(CSR_MAX_PAYLOAD_BYTES, MAX_PAYLOAD_RESET);
               end
            endcase
         end
         repeat (PHASE_WORDS) begin
            send_word(random_shape_word(), 1'b0, '0);
         end
      end

      drain_words();
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
